// File: design/gblur_pkg.sv
package gblur_pkg;

   // Frame bounds used as parameter defaults
   localparam int MAX_OUTER_DEF = 256;
   localparam int MAX_INNER_DEF = 256;

   // Kernel geometry
   localparam int KERNEL_SIZE = 9;
   localparam int KERNEL_HALF = KERNEL_SIZE / 2;
   localparam int QUAD_SIZE   = KERNEL_HALF + 1;
   localparam int TAP_W       = 4;

   // Datapath widths
   localparam int PIX_W     = 8;
   localparam int SIZE_W    = 9;
   localparam int COEF_W    = 11;
   localparam int FRAC_W    = 16;
   localparam int ACC_W     = 25;
   localparam int CSR_IDX_W = 1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd64;

   // Request codes
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EMIT = 1'b1;

   // Result status codes
   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_NOT_LOADED = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_SIZE = 1'b1;

   typedef logic [COEF_W-1:0] coef_type;

   // One quadrant of the symmetric sigma-3 kernel, Q0.16, row-major, center last
   localparam coef_type QUAD_COEF [QUAD_SIZE*QUAD_SIZE] = '{
      11'd263, 11'd386, 11'd509,  11'd600,  11'd634,
      11'd386, 11'd568, 11'd748,  11'd882,  11'd932,
      11'd509, 11'd748, 11'd985,  11'd1162, 11'd1227,
      11'd600, 11'd882, 11'd1162, 11'd1370, 11'd1448,
      11'd634, 11'd932, 11'd1227, 11'd1448, 11'd1530
   };

   // Commands from the controller to the datapath
   typedef struct packed {
      logic cfg_write;
      logic load;
      logic start;
      logic walk;
      logic put;
      logic put_early;
   } gblur_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic complete;
      logic walk_last;
      logic pipe_busy;
      logic out_free;
   } gblur_stat_type;

   // Fold a kernel tap onto the quadrant
   function automatic logic [2:0] fold_tap(input logic [TAP_W-1:0] t);
      if (t <= TAP_W'(KERNEL_HALF)) begin
         return t[2:0];
      end
      return 3'(TAP_W'(KERNEL_SIZE - 1) - t);
   endfunction

   // Coefficient of kernel tap (row, column)
   function automatic coef_type kernel_coef(input logic [TAP_W-1:0] fo,
                                            input logic [TAP_W-1:0] fi);
      logic [4:0] idx;
      idx = {2'b00, fold_tap(fo)} * 5'(QUAD_SIZE) + {2'b00, fold_tap(fi)};
      return QUAD_COEF[idx];
   endfunction

endpackage

// File: design/gblur_ctrl.sv
module gblur_ctrl
   import gblur_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_type,
   output logic           req_ready,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  gblur_stat_type stat,
   output gblur_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESULT
   } state_type;

   state_type state_ff;
   logic      early_ff;
   logic      accept;

   // Take requests and register writes only between requests
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign accept    = req_ready && req_valid;

   // Issue datapath commands
   always_comb begin
      cmd           = '0;
      cmd.cfg_write = csr_ready && csr_valid;
      cmd.load      = accept && (req_type == REQ_LOAD);
      cmd.start     = accept && (req_type == REQ_EMIT) && stat.complete;
      cmd.walk      = (state_ff == ST_WALK);
      cmd.put       = (state_ff == ST_RESULT) && !stat.pipe_busy && stat.out_free;
      cmd.put_early = early_ff;
   end

   // Advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         early_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_type == REQ_EMIT)) begin
                  if (stat.complete) begin
                     state_ff <= ST_WALK;
                     early_ff <= 1'b0;
                  end else begin
                     state_ff <= ST_RESULT;
                     early_ff <= 1'b1;
                  end
               end
            end
            ST_WALK: begin
               if (stat.walk_last) begin
                  state_ff <= ST_RESULT;
               end
            end
            ST_RESULT: begin
               if (cmd.put) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && stat.walk_last) |=> (state_ff == ST_RESULT))
      else $error("kernel walk did not hand over to result");

   a_walk_on_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> stat.complete)
      else $error("kernel walk without a complete frame");
`endif

endmodule

// File: design/gblur_dp.sv
module gblur_dp
   import gblur_pkg::*;
#(
   parameter int MAX_OUTER = MAX_OUTER_DEF,
   parameter int MAX_INNER = MAX_INNER_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  gblur_cmd_type        cmd,
   output gblur_stat_type       stat,
   input  logic [PIX_W-1:0]     req_pixel_value,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [PIX_W-1:0]     rsp_blurred_value,
   output logic                 rsp_last_pixel,
   output logic                 rsp_status
);

   localparam int OC_W  = (MAX_OUTER > 1) ? $clog2(MAX_OUTER) : 1;
   localparam int OS_W  = OC_W + 1;
   localparam int IC_W  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
   localparam int IS_W  = IC_W + 1;
   localparam int DEPTH = MAX_OUTER * MAX_INNER;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = OC_W + IS_W;
   localparam int PROD_W = PIX_W + COEF_W;

   // Size registers and frame bookkeeping
   logic [SIZE_W-1:0] outer_raw_ff, inner_raw_ff;
   logic              complete_ff;
   logic [OC_W-1:0]   lpo_ff, epo_ff;
   logic [IC_W-1:0]   lpi_ff, epi_ff;
   logic [AW-1:0]     ld_addr_ff;

   // Kernel walk and accumulate pipeline
   logic [OC_W-1:0]   so_ff, so_start;
   logic [IC_W-1:0]   si_ff, si_row_ff, si_start;
   logic [TAP_W-1:0]  fo_ff, fi_ff;
   logic [AW-1:0]     addr_ff;
   coef_type          coef1_ff, coef2_ff;
   logic              v1_ff, v2_ff;
   logic [PIX_W-1:0]  rd_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [PROD_W-1:0] product;
   logic [PW-1:0]     row_base;

   // Result register
   logic              rsp_valid_ff, rsp_last_ff, rsp_status_ff;
   logic [PIX_W-1:0]  rsp_value_ff, blurred;

   logic [PIX_W-1:0]  mem [DEPTH];

   logic [OS_W-1:0]   no;
   logic [IS_W-1:0]   ni;
   logic              load_last, emit_last, load_row_end, emit_row_end;

   function automatic logic [OS_W-1:0] clamp_outer(input logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return OS_W'(1);
      end
      if (int'(v) > MAX_OUTER) begin
         return OS_W'(MAX_OUTER);
      end
      return OS_W'(v);
   endfunction

   function automatic logic [IS_W-1:0] clamp_inner(input logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return IS_W'(1);
      end
      if (int'(v) > MAX_INNER) begin
         return IS_W'(MAX_INNER);
      end
      return IS_W'(v);
   endfunction

   function automatic logic end_o(input logic [OC_W-1:0] x, input logic [OS_W-1:0] n);
      return (OS_W'(x) + OS_W'(1)) == n;
   endfunction

   function automatic logic end_i(input logic [IC_W-1:0] x, input logic [IS_W-1:0] n);
      return (IS_W'(x) + IS_W'(1)) == n;
   endfunction

   function automatic logic [OC_W-1:0] inc_o(input logic [OC_W-1:0] x,
                                            input logic [OS_W-1:0] n);
      if (end_o(x, n)) begin
         return '0;
      end
      return x + OC_W'(1);
   endfunction

   function automatic logic [IC_W-1:0] inc_i(input logic [IC_W-1:0] x,
                                            input logic [IS_W-1:0] n);
      if (end_i(x, n)) begin
         return '0;
      end
      return x + IC_W'(1);
   endfunction

   function automatic logic [OC_W-1:0] dec_o(input logic [OC_W-1:0] x,
                                            input logic [OS_W-1:0] n);
      if (x == '0) begin
         return OC_W'(n - OS_W'(1));
      end
      return x - OC_W'(1);
   endfunction

   function automatic logic [IC_W-1:0] dec_i(input logic [IC_W-1:0] x,
                                            input logic [IS_W-1:0] n);
      if (x == '0) begin
         return IC_W'(n - IS_W'(1));
      end
      return x - IC_W'(1);
   endfunction

   assign no = clamp_outer(outer_raw_ff);
   assign ni = clamp_inner(inner_raw_ff);

   assign load_row_end = end_i(lpi_ff, ni);
   assign load_last    = end_o(lpo_ff, no) && load_row_end;
   assign emit_row_end = end_i(epi_ff, ni);
   assign emit_last    = end_o(epo_ff, no) && emit_row_end;

   // Step back half a kernel from the emit position, wrapping at the edges
   always_comb begin
      so_start = epo_ff;
      si_start = epi_ff;
      for (int k = 0; k < KERNEL_HALF; k++) begin
         so_start = dec_o(so_start, no);
         si_start = dec_i(si_start, ni);
      end
   end

   assign row_base = PW'(so_ff) * PW'(ni);
   assign product  = PROD_W'(rd_ff) * PROD_W'(coef2_ff);

   // Drop the fraction and saturate
   always_comb begin
      if (|acc_ff[ACC_W-1:FRAC_W+PIX_W]) begin
         blurred = '1;
      end else begin
         blurred = acc_ff[FRAC_W+PIX_W-1:FRAC_W];
      end
   end

   // Control state: sizes, positions, pipeline valids, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         outer_raw_ff <= SIZE_RESET;
         inner_raw_ff <= SIZE_RESET;
         complete_ff  <= 1'b0;
         lpo_ff       <= '0;
         lpi_ff       <= '0;
         ld_addr_ff   <= '0;
         epo_ff       <= '0;
         epi_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cfg_write) begin
            unique case (csr_index)
               CSR_OUTER_SIZE: outer_raw_ff <= csr_wdata;
               CSR_INNER_SIZE: inner_raw_ff <= csr_wdata;
               default: ;
            endcase
            complete_ff <= 1'b0;
            lpo_ff      <= '0;
            lpi_ff      <= '0;
            ld_addr_ff  <= '0;
            epo_ff      <= '0;
            epi_ff      <= '0;
         end else if (cmd.load && !complete_ff) begin
            // Advance the load position, close the frame on its last pixel
            if (load_last) begin
               complete_ff <= 1'b1;
               lpo_ff      <= '0;
               lpi_ff      <= '0;
               ld_addr_ff  <= '0;
            end else begin
               lpi_ff     <= inc_i(lpi_ff, ni);
               ld_addr_ff <= ld_addr_ff + AW'(1);
               if (load_row_end) begin
                  lpo_ff <= lpo_ff + OC_W'(1);
               end
            end
         end else if (cmd.put && !cmd.put_early) begin
            // Advance the emit position, reopen loading after the last pixel
            if (emit_last) begin
               complete_ff <= 1'b0;
               epo_ff      <= '0;
               epi_ff      <= '0;
            end else begin
               epi_ff <= inc_i(epi_ff, ni);
               if (emit_row_end) begin
                  epo_ff <= epo_ff + OC_W'(1);
               end
            end
         end

         v1_ff <= cmd.walk;
         v2_ff <= v1_ff;

         if (cmd.put) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Walk the 9x9 window in raster order, one tap per cycle
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         so_ff     <= so_start;
         si_ff     <= si_start;
         si_row_ff <= si_start;
         fo_ff     <= '0;
         fi_ff     <= '0;
      end else if (cmd.walk) begin
         if (fi_ff == TAP_W'(KERNEL_SIZE - 1)) begin
            fi_ff <= '0;
            si_ff <= si_row_ff;
            fo_ff <= fo_ff + TAP_W'(1);
            so_ff <= inc_o(so_ff, no);
         end else begin
            fi_ff <= fi_ff + TAP_W'(1);
            si_ff <= inc_i(si_ff, ni);
         end
      end
      if (cmd.walk) begin
         addr_ff  <= AW'(row_base + PW'(si_ff));
         coef1_ff <= kernel_coef(fo_ff, fi_ff);
      end
      coef2_ff <= coef1_ff;
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(product);
      end
   end

   // Frame memory: load writes, kernel walk reads
   always_ff @(posedge clock) begin
      if (cmd.load && !complete_ff) begin
         mem[ld_addr_ff] <= req_pixel_value;
      end
      rd_ff <= mem[addr_ff];
   end

   // Capture the result
   always_ff @(posedge clock) begin
      if (cmd.put) begin
         if (cmd.put_early) begin
            rsp_value_ff  <= '0;
            rsp_last_ff   <= 1'b0;
            rsp_status_ff <= STATUS_NOT_LOADED;
         end else begin
            rsp_value_ff  <= blurred;
            rsp_last_ff   <= emit_last;
            rsp_status_ff <= STATUS_OK;
         end
      end
   end

   assign stat.complete  = complete_ff;
   assign stat.walk_last = (fo_ff == TAP_W'(KERNEL_SIZE - 1)) &&
                           (fi_ff == TAP_W'(KERNEL_SIZE - 1));
   assign stat.pipe_busy = v1_ff || v2_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blurred_value = rsp_value_ff;
   assign rsp_last_pixel    = rsp_last_ff;
   assign rsp_status        = rsp_status_ff;

`ifndef SYNTHESIS
   a_put_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> !(v1_ff || v2_ff))
      else $error("result taken before the accumulator drained");

   a_early_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_NOT_LOADED) |->
      (rsp_value_ff == '0 && !rsp_last_ff))
      else $error("not-loaded result carries data");

   a_last_clears_frame: assert property (@(posedge clock) disable iff (reset)
      (cmd.put && !cmd.put_early && emit_last && !cmd.cfg_write) |=> !complete_ff)
      else $error("frame still marked complete after its last pixel");
`endif

endmodule

// File: design/wrapped_gaussian_blur_9x9.sv
// 9x9 Gaussian blur (sigma 3) with wraparound at all four frame edges.
// Request channel (req_*): req_type selects a load (req_pixel_value is the
// next source pixel in storage order, inner index fastest) or an emit.
// Result channel (rsp_*): one result per emit, none per load.
// Register port (csr_*): index 0 sets the outer size, index 1 the inner size;
// a write restarts the frame and is taken only between requests.
// Loads may follow back to back; loads after the frame is full are
// dropped. An emit before the frame is full returns status 1; its result
// register loads once the output register is free. A regular emit walks
// the 81 kernel taps, one frame memory read and one multiply-accumulate
// per cycle, and the result register loads once the accumulate pipeline
// has drained and the output register is free; the next request is taken
// in the following cycle, and no new request is taken while an emit runs.
// The result register frees the sequencer: a stalled receiver only holds
// a finished emit in its last step until rsp_ready rises.
// Reset clears positions and the frame-full flag and sets both sizes to 64;
// the frame memory is not cleared and needs no initialization pass.
module wrapped_gaussian_blur_9x9
   import gblur_pkg::*;
#(
   parameter int MAX_OUTER = MAX_OUTER_DEF,
   parameter int MAX_INNER = MAX_INNER_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [PIX_W-1:0]     req_pixel_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIX_W-1:0]     rsp_blurred_value,
   output logic                 rsp_last_pixel,
   output logic                 rsp_status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   gblur_cmd_type  cmd;
   gblur_stat_type stat;

   gblur_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gblur_dp #(
      .MAX_OUTER (MAX_OUTER),
      .MAX_INNER (MAX_INNER)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_pixel_value   (req_pixel_value),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_blurred_value (rsp_blurred_value),
      .rsp_last_pixel    (rsp_last_pixel),
      .rsp_status        (rsp_status)
   );

endmodule
